// ----- src/lcrf_pkg.sv -----
// Package for the largest connected region filter.
// Holds default geometry, register indexes, codes and the sequencer state type.
// Used by largest_connected_region_filter_unit, lcrf_checker and tb; depends on nothing.
package lcrf_pkg;

    // Default image geometry limits.
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 256;

    // Configuration register width and reset value.
    localparam int          CFG_W     = 9;
    localparam logic [8:0]  CFG_RESET = 9'd256;

    // Register indexes (byte address divided by four).
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // Input operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Pixel byte that marks a free pixel, and the blocked byte.
    localparam logic [7:0] FREE_BYTE = 8'hFF;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_OUT,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_ADDR,
        ST_NB_RD,
        ST_NB_CHK,
        ST_STATUS
    } lcrf_state_t;

endpackage

// ----- src/largest_connected_region_filter_unit.sv -----
// Top level of the largest connected region filter.
// Pixel, label and fill queue memories with a labeling sequencer.
// Depends on lcrf_pkg.

// Usage: pixels are loaded in raster order with op 0, one item per cycle while
// the block is idle. The item that carries tlast starts labeling: a clearing
// pass writes label 0 over the n = cols*rows active pixels, then a raster scan
// reads and checks each pixel, and every pixel of a free region is popped from
// the fill queue, after which its 3x3 neighbourhood (eight neighbors and itself)
// is visited position by position in address, read and check steps, set by the
// single read port of the pixel and label memories; a closing step ends each
// region. One status item follows. A read (op 1) is accepted while idle, and
// no new item is taken until its result has entered the output register.
// New items are taken while a finished result still waits in the output register.
module largest_connected_region_filter_unit
    import lcrf_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata fields from bit 0: pixel_value[7:0], read_index[23:8].
    input  logic [23:0] s_tdata,
    // s_tuser fields from bit 0: op[0].
    input  logic        s_tuser,
    // last_pixel.
    input  logic        s_tlast,
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields from bit 0: room_found[0], largest_area[17:1], out_pixel[25:18].
    output logic [31:0] m_tdata,
    // m_tuser fields from bit 0: is_status[0].
    output logic        m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CEW   = $clog2(MAX_COLS + 1);
    localparam int REW   = $clog2(MAX_ROWS + 1);
    localparam int LW    = $clog2(((MAX_COLS + 1) / 2) * ((MAX_ROWS + 1) / 2) + 1);
    localparam int QW    = RW + CW;

    // Memories.
    logic [7:0]    orig_mem [DEPTH];
    logic [LW-1:0] lab_mem  [DEPTH];
    logic [QW-1:0] q_mem    [DEPTH];

    lcrf_state_t state_reg, state_next;

    logic [CFG_W-1:0] cols_cfg_reg, rows_cfg_reg;
    logic [CEW-1:0]   cols_eff;
    logic [REW-1:0]   rows_eff;
    logic [NW-1:0]    n_reg, lab_n_reg;
    logic [AW-1:0]    load_cnt_reg;
    logic [AW-1:0]    p_reg;
    logic [CW-1:0]    sc_reg;
    logic [RW-1:0]    sr_reg;
    logic [RW-1:0]    r_reg;
    logic [CW-1:0]    c_reg;
    logic [1:0]       kr_reg, kc_reg;
    logic [AW-1:0]    q_reg;
    logic [QW-1:0]    nq_reg;
    logic             nb_ok_reg;
    logic [NW-1:0]    head_reg, tail_reg;
    logic [LW-1:0]    lab_cnt_reg, best_label_reg;
    logic [NW-1:0]    best_area_reg;
    logic             found_reg;
    logic [AW-1:0]    idx_reg;
    logic             idx_in_n_reg, idx_in_lab_reg;

    logic             m_valid_reg;
    logic             m_status_reg, m_found_reg;
    logic [16:0]      m_area_reg;
    logic [7:0]       m_pixel_reg;

    logic [7:0]       orig_rd;
    logic [LW-1:0]    lab_rd;
    logic [QW-1:0]    q_rd;

    // Control signals from the output decoder.
    logic             orig_we, lab_we, q_we;
    logic [AW-1:0]    lab_waddr, q_waddr, rd_addr, load_addr;
    logic [LW-1:0]    lab_wdata;
    logic [QW-1:0]    q_wdata;

    logic             s_acc, out_free, cfg_wr;
    logic [31:0]      idx32;
    logic [AW-1:0]    idx_in;
    logic [NW-1:0]    load_nxt;
    logic             scan_last, pix_new, nb_take;
    logic [RW:0]      nr_sum;
    logic [CW:0]      nc_sum;
    logic             nb_ok;
    logic [31:0]      area32;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    // Register read back.
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_ROWS) begin
            prdata[CFG_W-1:0] = rows_cfg_reg;
        end else begin
            prdata[CFG_W-1:0] = cols_cfg_reg;
        end
    end

    // Effective geometry, clamped to the supported range.
    always_comb begin
        if (cols_cfg_reg == '0) begin
            cols_eff = CEW'(1);
        end else if (32'(cols_cfg_reg) > 32'(MAX_COLS)) begin
            cols_eff = CEW'(MAX_COLS);
        end else begin
            cols_eff = CEW'(cols_cfg_reg);
        end
        if (rows_cfg_reg == '0) begin
            rows_eff = REW'(1);
        end else if (32'(rows_cfg_reg) > 32'(MAX_ROWS)) begin
            rows_eff = REW'(MAX_ROWS);
        end else begin
            rows_eff = REW'(rows_cfg_reg);
        end
    end

    // Read index and load address arithmetic.
    assign idx32  = {16'd0, s_tdata[23:8]};
    assign idx_in = idx32[AW-1:0];

    always_comb begin
        if ((NW'(load_cnt_reg)) >= n_reg) begin
            load_addr = '0;
        end else begin
            load_addr = load_cnt_reg;
        end
        load_nxt = NW'(load_addr) + NW'(1);
    end

    assign scan_last = (NW'(p_reg) + NW'(1)) == n_reg;
    assign pix_new   = (orig_rd == FREE_BYTE) && (lab_rd == '0);
    assign nb_take   = nb_ok_reg && pix_new;

    // Neighbor coordinates and bounds.
    always_comb begin
        nr_sum = ({1'b0, r_reg} + (RW+1)'(kr_reg)) - (RW+1)'(1);
        nc_sum = ({1'b0, c_reg} + (CW+1)'(kc_reg)) - (CW+1)'(1);
        nb_ok  = !(r_reg == '0 && kr_reg == 2'd0) && !(c_reg == '0 && kc_reg == 2'd0)
                 && (32'(nr_sum) < 32'(rows_eff)) && (32'(nc_sum) < 32'(cols_eff));
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == OP_READ) begin
                        state_next = ST_READ_OUT;
                    end else if (s_tlast) begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_READ_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                if (scan_last) begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (pix_new) begin
                    state_next = ST_POP;
                end else if (scan_last) begin
                    state_next = ST_STATUS;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_POP: begin
                if (head_reg != tail_reg) begin
                    state_next = ST_POP_WAIT;
                end else if (scan_last) begin
                    state_next = ST_STATUS;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_POP_WAIT: state_next = ST_NB_ADDR;
            ST_NB_ADDR:  state_next = ST_NB_RD;
            ST_NB_RD:    state_next = ST_NB_CHK;
            ST_NB_CHK: begin
                if (kr_reg == 2'd2 && kc_reg == 2'd2) begin
                    state_next = ST_POP;
                end else begin
                    state_next = ST_NB_ADDR;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory controls and handshake per state.
    always_comb begin
        s_tready  = 1'b0;
        orig_we   = 1'b0;
        lab_we    = 1'b0;
        q_we      = 1'b0;
        lab_waddr = p_reg;
        lab_wdata = '0;
        q_waddr   = tail_reg[AW-1:0];
        q_wdata   = nq_reg;
        rd_addr   = p_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                rd_addr  = idx_in;
                orig_we  = s_tvalid && (s_tuser == OP_LOAD);
            end
            ST_READ_OUT: rd_addr = idx_reg;
            ST_CLEAR:    lab_we  = 1'b1;
            ST_SCAN_CHK: begin
                lab_we    = pix_new;
                lab_wdata = lab_cnt_reg + LW'(1);
                q_we      = pix_new;
                q_waddr   = '0;
                q_wdata   = {sr_reg, sc_reg};
            end
            ST_NB_RD:  rd_addr = q_reg;
            ST_NB_CHK: begin
                rd_addr   = q_reg;
                lab_we    = nb_take;
                lab_waddr = q_reg;
                lab_wdata = lab_cnt_reg;
            end
            default: begin
            end
        endcase
        if (state_reg == ST_NB_CHK) begin
            q_we = nb_take;
        end
    end

    // Memory ports.
    always_ff @(posedge aclk) begin
        if (orig_we) begin
            orig_mem[load_addr] <= s_tdata[7:0];
        end
        if (lab_we) begin
            lab_mem[lab_waddr] <= lab_wdata;
        end
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        orig_rd <= orig_mem[rd_addr];
        lab_rd  <= lab_mem[rd_addr];
        q_rd    <= q_mem[head_reg[AW-1:0]];
    end

    // Configuration registers, state and geometry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg <= CFG_RESET;
            rows_cfg_reg <= CFG_RESET;
            state_reg    <= ST_IDLE;
            n_reg        <= NW'(DEPTH);
        end else begin
            if (cfg_wr && paddr[1:0] == 2'd0) begin
                if (paddr[2] == REG_ROWS) begin
                    rows_cfg_reg <= pwdata[CFG_W-1:0];
                end else begin
                    cols_cfg_reg <= pwdata[CFG_W-1:0];
                end
            end
            state_reg <= state_next;
            n_reg     <= NW'(32'(cols_eff) * 32'(rows_eff));
        end
    end

    // Labeling datapath and load counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg   <= '0;
            lab_n_reg      <= '0;
            best_area_reg  <= '0;
            best_label_reg <= '0;
            found_reg      <= 1'b0;
            lab_cnt_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            p_reg          <= '0;
            sr_reg         <= '0;
            sc_reg         <= '0;
            kr_reg         <= '0;
            kc_reg         <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && s_tuser == OP_LOAD) begin
                        if (s_tlast || load_nxt >= n_reg) begin
                            load_cnt_reg <= '0;
                        end else begin
                            load_cnt_reg <= load_nxt[AW-1:0];
                        end
                        if (s_tlast) begin
                            lab_n_reg      <= n_reg;
                            best_area_reg  <= '0;
                            best_label_reg <= '0;
                            found_reg      <= 1'b0;
                            lab_cnt_reg    <= '0;
                            p_reg          <= '0;
                        end
                    end
                end
                ST_CLEAR: begin
                    if (scan_last) begin
                        p_reg  <= '0;
                        sr_reg <= '0;
                        sc_reg <= '0;
                    end else begin
                        p_reg <= p_reg + AW'(1);
                    end
                end
                ST_SCAN_CHK: begin
                    if (pix_new) begin
                        lab_cnt_reg <= lab_cnt_reg + LW'(1);
                        head_reg    <= '0;
                        tail_reg    <= NW'(1);
                    end else begin
                        p_reg <= p_reg + AW'(1);
                        if (32'(sc_reg) + 1 == 32'(cols_eff)) begin
                            sc_reg <= '0;
                            sr_reg <= sr_reg + RW'(1);
                        end else begin
                            sc_reg <= sc_reg + CW'(1);
                        end
                    end
                end
                ST_POP: begin
                    if (head_reg == tail_reg) begin
                        // Region complete: later regions win ties.
                        if (tail_reg >= best_area_reg) begin
                            best_area_reg  <= tail_reg;
                            best_label_reg <= lab_cnt_reg;
                        end
                        found_reg <= 1'b1;
                        p_reg     <= p_reg + AW'(1);
                        if (32'(sc_reg) + 1 == 32'(cols_eff)) begin
                            sc_reg <= '0;
                            sr_reg <= sr_reg + RW'(1);
                        end else begin
                            sc_reg <= sc_reg + CW'(1);
                        end
                    end
                end
                ST_POP_WAIT: begin
                    r_reg    <= q_rd[QW-1:CW];
                    c_reg    <= q_rd[CW-1:0];
                    head_reg <= head_reg + NW'(1);
                    kr_reg   <= '0;
                    kc_reg   <= '0;
                end
                ST_NB_ADDR: begin
                    nb_ok_reg <= nb_ok;
                    nq_reg    <= {nr_sum[RW-1:0], nc_sum[CW-1:0]};
                    q_reg     <= AW'(32'(nr_sum[RW-1:0]) * 32'(cols_eff)
                                     + 32'(nc_sum[CW-1:0]));
                end
                ST_NB_CHK: begin
                    if (nb_take) begin
                        tail_reg <= tail_reg + NW'(1);
                    end
                    if (kc_reg == 2'd2) begin
                        kc_reg <= '0;
                        kr_reg <= kr_reg + 2'd1;
                    end else begin
                        kc_reg <= kc_reg + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Read request bookkeeping.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            idx_reg        <= idx_in;
            idx_in_n_reg   <= 32'(s_tdata[23:8]) < 32'(n_reg);
            idx_in_lab_reg <= 32'(s_tdata[23:8]) < 32'(lab_n_reg);
        end
    end

    assign area32 = 32'(best_area_reg);

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (out_free && (state_reg == ST_READ_OUT || state_reg == ST_STATUS)) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && (state_reg == ST_READ_OUT || state_reg == ST_STATUS)) begin
            m_status_reg <= (state_reg == ST_STATUS);
            m_found_reg  <= found_reg;
            m_area_reg   <= area32[16:0];
            if (state_reg == ST_STATUS || !idx_in_n_reg) begin
                m_pixel_reg <= ZERO_BYTE;
            end else if (found_reg) begin
                m_pixel_reg <= (idx_in_lab_reg && lab_rd == best_label_reg)
                               ? FREE_BYTE : ZERO_BYTE;
            end else begin
                m_pixel_reg <= orig_rd;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {6'd0, m_pixel_reg, m_area_reg, m_found_reg};

endmodule

// ----- tb/lcrf_checker.sv -----
// Checker for the largest connected region filter: watches the input, result and
// configuration ports, predicts every result and compares it with what arrives.
// Depends on lcrf_pkg for the operation and pixel codes.
`timescale 1ns / 100ps

module lcrf_checker
    import lcrf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatch_count,
    output int          pending_count
);

    typedef struct packed {
        logic        is_status;
        logic        room_found;
        logic [16:0] largest_area;
        logic [7:0]  out_pixel;
    } filt_result_t;

    localparam int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS;

    // Shadow of the block's state.
    logic [8:0]   cols_reg;
    logic [8:0]   rows_reg;
    logic [7:0]   pixel_store [DEPTH];
    int           region_of [DEPTH];
    int           best_area;
    int           best_region;
    int           load_ptr;
    logic         room_flag;
    filt_result_t expected_results [$];

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    // Register value as the block uses it: zero means one, above the maximum saturates.
    function automatic int clamp_dim(input logic [8:0] v, input int max_v);
        if (v == 9'd0) return 1;
        if (int'(v) > max_v) return max_v;
        return int'(v);
    endfunction

    // Labels the 8-connected free regions and keeps the largest, later region on ties.
    function automatic void label_regions();
        int cols, rows, n, nregion, area, q, r, c, nr, nc, nb, dr, dc;
        int fill [$];
        cols = clamp_dim(cols_reg, DEF_MAX_COLS);
        rows = clamp_dim(rows_reg, DEF_MAX_ROWS);
        n = cols * rows;
        for (int i = 0; i < DEPTH; i++) region_of[i] = 0;
        best_area   = 0;
        best_region = 0;
        room_flag   = 1'b0;
        nregion     = 0;
        for (int p = 0; p < n; p++) begin
            if (pixel_store[p] == FREE_BYTE && region_of[p] == 0) begin
                nregion++;
                region_of[p] = nregion;
                fill.delete();
                fill = {fill, p};
                area = 1;
                while (fill.size() > 0) begin
                    q = fill.pop_front();
                    r = q / cols;
                    c = q % cols;
                    for (dr = -1; dr <= 1; dr++) begin
                        for (dc = -1; dc <= 1; dc++) begin
                            nr = r + dr;
                            nc = c + dc;
                            if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
                                nb = nr * cols + nc;
                                if (pixel_store[nb] == FREE_BYTE && region_of[nb] == 0) begin
                                    region_of[nb] = nregion;
                                    fill = {fill, nb};
                                    area++;
                                end
                            end
                        end
                    end
                end
                if (area >= best_area) begin
                    best_area   = area;
                    best_region = nregion;
                end
                room_flag = 1'b1;
            end
        end
    endfunction

    // Works out the result of one accepted item, if it has one.
    function automatic void predict_item(input logic op, input logic [7:0] pix,
                                         input logic last, input logic [15:0] idx);
        int n;
        filt_result_t res;
        n = clamp_dim(cols_reg, DEF_MAX_COLS) * clamp_dim(rows_reg, DEF_MAX_ROWS);
        if (op == OP_LOAD) begin
            if (load_ptr >= n) load_ptr = 0;
            pixel_store[load_ptr] = pix;
            load_ptr++;
            if (load_ptr >= n) load_ptr = 0;
            if (last) begin
                load_ptr = 0;
                label_regions();
                res.is_status    = 1'b1;
                res.room_found   = room_flag;
                res.largest_area = best_area[16:0];
                res.out_pixel    = ZERO_BYTE;
                expected_results = {expected_results, res};
            end
        end else begin
            res.is_status    = 1'b0;
            res.room_found   = room_flag;
            res.largest_area = best_area[16:0];
            res.out_pixel    = ZERO_BYTE;
            if (int'(idx) < n) begin
                if (room_flag)
                    res.out_pixel = (region_of[idx] == best_region) ? FREE_BYTE : ZERO_BYTE;
                else
                    res.out_pixel = pixel_store[idx];
            end
            expected_results = {expected_results, res};
        end
    endfunction

    // Results are taken before inputs so a result never meets an expectation pushed
    // at the same edge.
    always @(posedge aclk) begin
        filt_result_t want;
        filt_result_t got;
        if (!aresetn) begin
            cols_reg    <= CFG_RESET;
            rows_reg    <= CFG_RESET;
            best_area   = 0;
            best_region = 0;
            load_ptr    = 0;
            room_flag   = 1'b0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[0], m_tdata[17:1], m_tdata[25:18]};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result item: status %0d room %0d area %0d pixel %0d",
                                 got.is_status, got.room_found, got.largest_area, got.out_pixel);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: expected status %0d room %0d area %0d pixel %0d, %s",
                                     want.is_status, want.room_found, want.largest_area,
                                     want.out_pixel,
                                     $sformatf("got status %0d room %0d area %0d pixel %0d",
                                               got.is_status, got.room_found,
                                               got.largest_area, got.out_pixel));
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata[7:0], s_tlast, s_tdata[23:8]);
            if (psel && penable && pwrite && pready) begin
                if (paddr == 3'd0) cols_reg <= pwdata[8:0];
                else if (paddr == 3'd4) rows_reg <= pwdata[8:0];
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for largest_connected_region_filter_unit: drives images, reads and
// register writes, and gives the verdict from the checker's counts.
// Depends on lcrf_pkg, the block and lcrf_checker.
`timescale 1ns / 100ps

module tb;
    import lcrf_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatch_count;
    int          pending_count;

    int tx_idle = 27;
    int rx_idle = 45;
    int items_sent = 0;
    int swap_at = 1_000_000;
    int calm_at = 1_000_000;
    int img_cols = 256;
    int img_rows = 256;
    logic hold_req = 1'b0;

    always #4 aclk = ~aclk;

    largest_connected_region_filter_unit DUT (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    lcrf_checker checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .mismatch_count, .pending_count
    );

    // Result side: random stalls, or one long hold-off when it is requested.
    always @(posedge aclk) begin
        int hold_left;
        bit hold_taken;
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Offers one item and returns once it has been accepted.
    task automatic send_item(input logic op, input logic [7:0] pix, input logic last,
                             input logic [15:0] idx);
        // Idle mix by item count: swapped first, then no idling at all.
        if (items_sent >= calm_at) begin
            tx_idle = 0;
            rx_idle = 0;
        end else if (items_sent >= swap_at) begin
            tx_idle = 45;
            rx_idle = 27;
        end
        if ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {idx, pix};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    function automatic logic [7:0] rand_pixel();
        return ($urandom_range(99) < 60) ? FREE_BYTE : 8'($urandom_range(255));
    endfunction

    // Loads count random pixels, the final one flagged as the last.
    task automatic load_image(input int count);
        for (int i = 0; i < count; i++)
            send_item(OP_LOAD, rand_pixel(), i == count - 1, 16'($urandom));
    endtask

    task automatic read_pixel(input int idx);
        send_item(OP_READ, 8'($urandom), 1'($urandom), 16'(idx));
    endtask

    // Waits until every expected result is in and the block has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // New geometry, then a full image so every active pixel has been written.
    task automatic set_geometry(input logic [8:0] cols, input logic [8:0] rows);
        wait_idle();
        write_reg({REG_COLS, 2'b00}, 32'(cols));
        write_reg({REG_ROWS, 2'b00}, 32'(rows));
        img_cols = (cols == 0) ? 1 : ((cols > 256) ? 256 : int'(cols));
        img_rows = (rows == 0) ? 1 : ((rows > 256) ? 256 : int'(rows));
        load_image(img_cols * img_rows);
    endtask

    task automatic load_fixed(input logic [7:0] pix [9]);
        for (int i = 0; i < 9; i++) send_item(OP_LOAD, pix[i], i == 8, 16'($urandom));
    endtask

    initial begin
        logic [7:0] img [9];
        int n, choice, target;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reads before any labeling return the loaded bytes.
        write_reg({REG_COLS, 2'b00}, 32'd3);
        write_reg({REG_ROWS, 2'b00}, 32'd3);
        img_cols = 3;
        img_rows = 3;
        send_item(OP_LOAD, FREE_BYTE, 1'b0, 16'hFFFF);
        send_item(OP_LOAD, 8'd254, 1'b0, 16'h0000);
        read_pixel(0);
        read_pixel(1);
        img = '{8'd0, FREE_BYTE, FREE_BYTE, 8'd0, 8'd0, 8'd0, 8'd128, FREE_BYTE, 8'd1};
        for (int i = 2; i < 9; i++) send_item(OP_LOAD, img[i], i == 8, 16'($urandom));
        for (int i = 0; i < 9; i++) read_pixel(i);
        // Reads out of range.
        read_pixel(9);
        read_pixel(65535);
        // No free pixel at all: original bytes come back.
        img = '{8'd0, 8'd254, 8'd127, 8'd1, 8'd128, 8'd64, 8'd2, 8'd253, 8'd0};
        load_fixed(img);
        read_pixel(1);
        read_pixel(7);
        // Two regions of equal size: the later one wins.
        img = '{FREE_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, FREE_BYTE};
        load_fixed(img);
        read_pixel(0);
        read_pixel(8);
        // Too many loads wrap around; a short image labels what the store holds.
        load_image(11);
        read_pixel(4);
        load_image(4);
        read_pixel(2);

        // Register extremes: above the maximum and zero.
        set_geometry(9'd511, 9'd0);
        read_pixel(255);
        read_pixel(256);
        // The store already holds all 256 active pixels, so a short image labels them.
        wait_idle();
        write_reg({REG_COLS, 2'b00}, 32'd0);
        write_reg({REG_ROWS, 2'b00}, 32'd256);
        img_cols = 1;
        img_rows = 256;
        load_image(2);
        read_pixel(0);
        read_pixel(255);
        set_geometry(9'd1, 9'd1);
        read_pixel(0);

        // Long receiver hold-off while reads keep coming.
        hold_req = 1'b1;
        repeat (40) read_pixel(0);

        // Random phases of geometry, images and reads.
        target  = items_sent + 260;
        swap_at = target - 180;
        calm_at = target - 90;
        while (items_sent < target) begin
            set_geometry(9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)));
            n = img_cols * img_rows;
            repeat ($urandom_range(3, 8)) begin
                choice = $urandom_range(99);
                if (choice < 65) begin
                    repeat ($urandom_range(1, 8))
                        read_pixel(($urandom_range(9) == 0) ? $urandom_range(65535)
                                                            : $urandom_range(n - 1));
                end else if (choice < 80) begin
                    load_image(n);
                end else if (choice < 92) begin
                    load_image($urandom_range(1, n + 3));
                end else begin
                    repeat ($urandom_range(1, 3))
                        send_item(OP_LOAD, rand_pixel(), 1'b0, 16'($urandom));
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
